@@ rtl/core/gpf_pkg.sv @@
// Package for the gravity pair force pipeline: field widths, internal
// arithmetic widths, register reset values and register indexes.
// No dependencies.
package gpf_pkg;

	localparam int COORD_W = 32;
	localparam int MASS_W  = 32;
	localparam int CFG_W   = 32;
	localparam int FORCE_W = 48;

	localparam int DIFF_W  = COORD_W + 1;         // signed separation
	localparam int MAG_W   = DIFF_W;              // |separation|, up to 2^32
	localparam int SQ_W    = 2 * MAG_W;           // squared length, Q34.32
	localparam int ROOT_W  = SQ_W / 2;            // distance
	localparam int GM_W    = CFG_W + MASS_W;      // G*m1
	localparam int NUM_W   = GM_W + MASS_W;       // G*m1*m2
	localparam int FRAC_W  = 32;                  // unit vector fraction bits
	localparam int UNUM_W  = MAG_W + FRAC_W;      // |c| * 2^32
	localparam int U_W     = FRAC_W + 1;          // unit component, up to 2^32
	localparam int S_W     = FORCE_W + FRAC_W;    // clamped scalar, up to 2^79
	localparam int PROD_W  = S_W + U_W;           // scalar * unit component

	localparam logic [CFG_W-1:0] G_RESET        = CFG_W'(65536);
	localparam logic [CFG_W-1:0] MIN_DIST_RESET = CFG_W'(1966080);

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRAVITY  = 1'b0,
		REG_MIN_DIST = 1'b1
	} cfg_reg_t;

endpackage

@@ rtl/core/gpf_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, side data
// travels with each beat. Depends on gpf_pkg for default widths.
module gpf_div_pipe import gpf_pkg::*; #(
	parameter int N_W    = NUM_W,
	parameter int D_W    = SQ_W,
	parameter int Q_W    = NUM_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [N_W-1:0]    num,
	input  logic [D_W-1:0]    den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] side_out
);

	logic [N_W+D_W-1:0] num_ext;
	logic [Q_W:1]       vld_s;
	logic [D_W-1:0]     rem_s  [1:Q_W];
	logic [Q_W-1:0]     acc_s  [1:Q_W];
	logic [D_W-1:0]     den_s  [1:Q_W];
	logic [SIDE_W-1:0]  side_s [1:Q_W];

	// high numerator bits seed the remainder; quotient must fit in Q_W bits
	assign num_ext = {{D_W{1'b0}}, num};

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic              p_vld;
		logic [D_W-1:0]    p_rem;
		logic [Q_W-1:0]    p_acc;
		logic [D_W-1:0]    p_den;
		logic [SIDE_W-1:0] p_side;
		logic [D_W:0]      t;
		logic [D_W:0]      diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign p_vld  = in_vld;
			assign p_rem  = num_ext[Q_W +: D_W];
			assign p_acc  = num[Q_W-1:0];
			assign p_den  = den;
			assign p_side = side_in;
		end else begin : g_next
			assign p_vld  = vld_s[k];
			assign p_rem  = rem_s[k];
			assign p_acc  = acc_s[k];
			assign p_den  = den_s[k];
			assign p_side = side_s[k];
		end

		assign t    = {p_rem, p_acc[Q_W-1]};
		assign ge   = t >= {1'b0, p_den};
		assign diff = t - {1'b0, p_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[D_W-1:0] : t[D_W-1:0];
			acc_s[k+1]  <= {p_acc[Q_W-2:0], ge};
			den_s[k+1]  <= p_den;
			side_s[k+1] <= p_side;
		end
	end

	assign out_vld  = vld_s[Q_W];
	assign quo      = acc_s[Q_W];
	assign side_out = side_s[Q_W];

endmodule

@@ rtl/core/gpf_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage, side data
// travels with each beat. Depends on gpf_pkg for the default width.
module gpf_sqrt_pipe import gpf_pkg::*; #(
	parameter int RT_W   = ROOT_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [2*RT_W-1:0] rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [RT_W-1:0]   root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int RAD_W = 2 * RT_W;
	localparam int REM_W = RT_W + 2;
	localparam int T_W   = REM_W + 2;

	logic [RT_W:1]      vld_s;
	logic [REM_W-1:0]   rem_s  [1:RT_W];
	logic [RT_W-1:0]    root_s [1:RT_W];
	logic [RAD_W-1:0]   rad_s  [1:RT_W];
	logic [SIDE_W-1:0]  side_s [1:RT_W];

	for (genvar k = 0; k < RT_W; k++) begin : g_step
		logic              p_vld;
		logic [REM_W-1:0]  p_rem;
		logic [RT_W-1:0]   p_root;
		logic [RAD_W-1:0]  p_rad;
		logic [SIDE_W-1:0] p_side;
		logic [T_W-1:0]    t;
		logic [T_W-1:0]    trial;
		logic [T_W-1:0]    diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign p_vld  = in_vld;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rad  = rad;
			assign p_side = side_in;
		end else begin : g_next
			assign p_vld  = vld_s[k];
			assign p_rem  = rem_s[k];
			assign p_root = root_s[k];
			assign p_rad  = rad_s[k];
			assign p_side = side_s[k];
		end

		assign t     = {p_rem, p_rad[RAD_W-1 -: 2]};
		assign trial = T_W'({p_root, 2'b01});
		assign ge    = t >= trial;
		assign diff  = t - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
			root_s[k+1] <= {p_root[RT_W-2:0], ge};
			rad_s[k+1]  <= p_rad << 2;
			side_s[k+1] <= p_side;
		end
	end

	assign out_vld  = vld_s[RT_W];
	assign root     = root_s[RT_W];
	assign side_out = side_s[RT_W];

endmodule

@@ rtl/core/gravity_pair_force.sv @@
// Top level of the gravity pair force pipeline.
// Depends on gpf_pkg, gpf_sqrt_pipe and gpf_div_pipe.
//
// One body pair is taken on every clock at which start is high; busy is
// always low. Each pair gives one result beat, marked by done for a single
// cycle, after 3 input stages, 33 square root stages, 1 stage for
// the squared distance, 96 stages for G*m1*m2/D^2, 33 stages for
// the unit vector and 3 stages for scaling, saturation and
// sign. The result cannot be held off, so it must be captured when done is
// high. gravity_constant and min_distance are written through cfg_we,
// cfg_index and cfg_data and must only change while no pair is in flight.
module gravity_pair_force import gpf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] first_x,
	input  logic signed [COORD_W-1:0] first_y,
	input  logic [MASS_W-1:0]         first_mass,
	input  logic signed [COORD_W-1:0] second_x,
	input  logic signed [COORD_W-1:0] second_y,
	input  logic [MASS_W-1:0]         second_mass,
	output logic                      done,
	output logic signed [FORCE_W-1:0] force_x,
	output logic signed [FORCE_W-1:0] force_y,
	output logic                      applied
);

	localparam int LAT   = 3 + ROOT_W + 1 + NUM_W + U_W + 3;
	localparam int FM_W  = FORCE_W - 1;
	localparam int MAG2_W = PROD_W - FRAC_W;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic             neg_x;
		logic             neg_y;
	} sqrt_side_t;

	typedef struct packed {
		logic [ROOT_W-1:0] dlen;
		logic [MAG_W-1:0]  mag_x;
		logic [MAG_W-1:0]  mag_y;
		logic              neg_x;
		logic              neg_y;
		logic              applied;
		logic              fire;
	} div_side_t;

	typedef struct packed {
		logic [S_W-1:0] s;
		logic           neg_x;
		logic           applied;
		logic           fire;
	} unit_side_t;

	logic [CFG_W-1:0] grav_q;
	logic [CFG_W-1:0] min_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q    <= G_RESET;
			min_len_q <= MIN_DIST_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRAVITY:  grav_q    <= cfg_data;
				REG_MIN_DIST: min_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: separation, magnitudes, G*m1
	logic signed [DIFF_W-1:0] dx_c, dy_c;
	logic [GM_W-1:0]          gm_c;

	assign dx_c = DIFF_W'(second_x) - DIFF_W'(first_x);
	assign dy_c = DIFF_W'(second_y) - DIFF_W'(first_y);
	assign gm_c = grav_q * first_mass;

	logic              vld_s1;
	logic [MAG_W-1:0]  magx_s1, magy_s1;
	logic              negx_s1, negy_s1;
	logic [GM_W-1:0]   gm_s1;
	logic [MASS_W-1:0] m2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		magx_s1 <= dx_c[DIFF_W-1] ? MAG_W'(-dx_c) : MAG_W'(dx_c);
		magy_s1 <= dy_c[DIFF_W-1] ? MAG_W'(-dy_c) : MAG_W'(dy_c);
		negx_s1 <= dx_c[DIFF_W-1];
		negy_s1 <= dy_c[DIFF_W-1];
		gm_s1   <= gm_c;
		m2_s1   <= second_mass;
	end

	// stage 2: squares and partial products of G*m1*m2
	logic [SQ_W-1:0] sqx_c, sqy_c;
	logic [GM_W-1:0] pplo_c, pphi_c;

	assign sqx_c  = magx_s1 * magx_s1;
	assign sqy_c  = magy_s1 * magy_s1;
	assign pplo_c = gm_s1[GM_W/2-1:0] * m2_s1;
	assign pphi_c = gm_s1[GM_W-1:GM_W/2] * m2_s1;

	logic             vld_s2;
	logic [SQ_W-1:0]  sqx_s2, sqy_s2;
	logic [GM_W-1:0]  pplo_s2, pphi_s2;
	logic [MAG_W-1:0] magx_s2, magy_s2;
	logic             negx_s2, negy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s2  <= sqx_c;
		sqy_s2  <= sqy_c;
		pplo_s2 <= pplo_c;
		pphi_s2 <= pphi_c;
		magx_s2 <= magx_s1;
		magy_s2 <= magy_s1;
		negx_s2 <= negx_s1;
		negy_s2 <= negy_s1;
	end

	// stage 3: sums
	logic             vld_s3;
	logic [SQ_W-1:0]  d2_s3;
	logic [NUM_W-1:0] num_s3;
	logic [MAG_W-1:0] magx_s3, magy_s3;
	logic             negx_s3, negy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		d2_s3   <= sqx_s2 + sqy_s2;
		num_s3  <= NUM_W'(pplo_s2) + NUM_W'({pphi_s2, {(GM_W/2){1'b0}}});
		magx_s3 <= magx_s2;
		magy_s3 <= magy_s2;
		negx_s3 <= negx_s2;
		negy_s3 <= negy_s2;
	end

	// square root
	sqrt_side_t        sq_in, sq_out;
	logic              sq_vld;
	logic [ROOT_W-1:0] dist_c;

	assign sq_in = '{num: num_s3, mag_x: magx_s3, mag_y: magy_s3,
		neg_x: negx_s3, neg_y: negy_s3};

	gpf_sqrt_pipe #(
		.RT_W   (ROOT_W),
		.SIDE_W ($bits(sqrt_side_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.rad      (d2_s3),
		.side_in  (sq_in),
		.out_vld  (sq_vld),
		.root     (dist_c),
		.side_out (sq_out)
	);

	// stage 4: squared distance and threshold
	logic [SQ_W-1:0] dsq_c;
	assign dsq_c = dist_c * dist_c;

	logic             vld_s4;
	logic [SQ_W-1:0]  dsq_s4;
	logic [NUM_W-1:0] num_s4;
	div_side_t        dside_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		dsq_s4           <= dsq_c;
		num_s4           <= sq_out.num;
		dside_s4.dlen    <= dist_c;
		dside_s4.mag_x   <= sq_out.mag_x;
		dside_s4.mag_y   <= sq_out.mag_y;
		dside_s4.neg_x   <= sq_out.neg_x;
		dside_s4.neg_y   <= sq_out.neg_y;
		dside_s4.applied <= dist_c >= ROOT_W'(min_len_q);
		dside_s4.fire    <= (dist_c >= ROOT_W'(min_len_q)) && (dist_c != '0);
	end

	// G*m1*m2 / D^2
	logic             dv_vld;
	logic [NUM_W-1:0] quo_c;
	div_side_t        dside_o;

	gpf_div_pipe #(
		.N_W    (NUM_W),
		.D_W    (SQ_W),
		.Q_W    (NUM_W),
		.SIDE_W ($bits(div_side_t))
	) u_div_s (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.num      (num_s4),
		.den      (dsq_s4),
		.side_in  (dside_s4),
		.out_vld  (dv_vld),
		.quo      (quo_c),
		.side_out (dside_o)
	);

	// any scalar at or above 2^79 saturates whenever the unit component is nonzero
	logic [S_W-1:0] s_c;
	assign s_c = (|quo_c[NUM_W-1:S_W-1]) ? {1'b1, {(S_W-1){1'b0}}} : quo_c[S_W-1:0];

	unit_side_t        ux_in, ux_out;
	logic              ux_vld, uy_vld;
	logic [U_W-1:0]    ux_c, uy_c;
	logic              negy_o;

	assign ux_in = '{s: s_c, neg_x: dside_o.neg_x, applied: dside_o.applied,
		fire: dside_o.fire};

	gpf_div_pipe #(
		.N_W    (UNUM_W),
		.D_W    (ROOT_W),
		.Q_W    (U_W),
		.SIDE_W ($bits(unit_side_t))
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (dv_vld),
		.num      ({dside_o.mag_x, {FRAC_W{1'b0}}}),
		.den      (dside_o.dlen),
		.side_in  (ux_in),
		.out_vld  (ux_vld),
		.quo      (ux_c),
		.side_out (ux_out)
	);

	gpf_div_pipe #(
		.N_W    (UNUM_W),
		.D_W    (ROOT_W),
		.Q_W    (U_W),
		.SIDE_W (1)
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (dv_vld),
		.num      ({dside_o.mag_y, {FRAC_W{1'b0}}}),
		.den      (dside_o.dlen),
		.side_in  (dside_o.neg_y),
		.out_vld  (uy_vld),
		.quo      (uy_c),
		.side_out (negy_o)
	);

	// stage 5: partial products of scalar and unit components
	logic [FRAC_W+U_W-1:0]     px0_c, px1_c, py0_c, py1_c;
	logic [S_W-2*FRAC_W+U_W-1:0] px2_c, py2_c;

	assign px0_c = ux_out.s[FRAC_W-1:0] * ux_c;
	assign px1_c = ux_out.s[2*FRAC_W-1:FRAC_W] * ux_c;
	assign px2_c = ux_out.s[S_W-1:2*FRAC_W] * ux_c;
	assign py0_c = ux_out.s[FRAC_W-1:0] * uy_c;
	assign py1_c = ux_out.s[2*FRAC_W-1:FRAC_W] * uy_c;
	assign py2_c = ux_out.s[S_W-1:2*FRAC_W] * uy_c;

	logic                        vld_s5;
	logic [FRAC_W+U_W-1:0]       px0_s5, px1_s5, py0_s5, py1_s5;
	logic [S_W-2*FRAC_W+U_W-1:0] px2_s5, py2_s5;
	logic                        negx_s5, negy_s5, appl_s5, fire_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= ux_vld && uy_vld;
		end
	end

	always_ff @(posedge clk) begin
		px0_s5  <= px0_c;
		px1_s5  <= px1_c;
		px2_s5  <= px2_c;
		py0_s5  <= py0_c;
		py1_s5  <= py1_c;
		py2_s5  <= py2_c;
		negx_s5 <= ux_out.neg_x;
		negy_s5 <= negy_o;
		appl_s5 <= ux_out.applied;
		fire_s5 <= ux_out.fire;
	end

	// stage 6: sum, drop fraction, saturate
	logic [PROD_W-1:0] sumx_c, sumy_c;
	logic [MAG2_W-1:0] magx_c, magy_c;

	assign sumx_c = PROD_W'(px0_s5) + PROD_W'({px1_s5, {FRAC_W{1'b0}}})
		+ PROD_W'({px2_s5, {(2*FRAC_W){1'b0}}});
	assign sumy_c = PROD_W'(py0_s5) + PROD_W'({py1_s5, {FRAC_W{1'b0}}})
		+ PROD_W'({py2_s5, {(2*FRAC_W){1'b0}}});
	assign magx_c = sumx_c[PROD_W-1:FRAC_W];
	assign magy_c = sumy_c[PROD_W-1:FRAC_W];

	logic            vld_s6;
	logic [FM_W-1:0] fmx_s6, fmy_s6;
	logic            negx_s6, negy_s6, appl_s6, fire_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		fmx_s6  <= (|magx_c[MAG2_W-1:FM_W]) ? {FM_W{1'b1}} : magx_c[FM_W-1:0];
		fmy_s6  <= (|magy_c[MAG2_W-1:FM_W]) ? {FM_W{1'b1}} : magy_c[FM_W-1:0];
		negx_s6 <= negx_s5;
		negy_s6 <= negy_s5;
		appl_s6 <= appl_s5;
		fire_s6 <= fire_s5;
	end

	// output beat
	logic               done_q;
	logic [FORCE_W-1:0] force_x_q, force_y_q;
	logic               applied_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (!fire_s6) begin
			force_x_q <= '0;
			force_y_q <= '0;
		end else begin
			force_x_q <= negx_s6 ? FORCE_W'(0) - {1'b0, fmx_s6} : {1'b0, fmx_s6};
			force_y_q <= negy_s6 ? FORCE_W'(0) - {1'b0, fmy_s6} : {1'b0, fmy_s6};
		end
		applied_q <= appl_s6;
	end

	assign done    = done_q;
	assign force_x = force_x_q;
	assign force_y = force_y_q;
	assign applied = applied_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("beat did not complete at fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result beat without a start");

	a_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		done && !applied |-> force_x == '0 && force_y == '0)
		else $error("force on a pair below minimum distance");

	a_sat_sym: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> force_x != {1'b1, {FM_W{1'b0}}} && force_y != {1'b1, {FM_W{1'b0}}})
		else $error("force outside symmetric saturation range");

endmodule
